/* design/assert_macros.svh */
// Assertion helpers shared by the spline evaluator modules.
// Each use expects clk_i and rst_ni in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define CRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset
`define CRS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* design/crs_pkg.sv */
`timescale 1ns / 1ps
package crs_pkg;

  // Default coordinate and fraction widths
  localparam int unsigned CRS_COORD_BITS = 16;
  localparam int unsigned CRS_FRAC_BITS  = 16;

  // Entries in the queue between front and back
  localparam int unsigned CRS_QUEUE_DEPTH = 2;

  // Queue fill status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* design/catmull_rom_segment_eval_unit.sv */
`timescale 1ns / 1ps
// Uniform 2D Catmull-Rom segment evaluator. Each item carries four control
// points and a fraction u = frac/2^FracBits (values above one are clamped to
// one); the result is the point on the segment from P1 to P2, rounded to
// nearest with halves toward plus infinity. While nothing stalls, a new item
// is taken every clock and one result leaves every clock; an accepted item
// passes through the queue, the three Horner stage registers and the output
// register. The front computes the curve coefficients and writes a
// two-entry queue; the back runs a Horner pipeline per coordinate: two stages
// with one multiply each, a third whose product is split in two halves, and
// an output register that recombines the halves, adds the start point and
// rounds. Input stall rises only when the queue is full, which happens only
// after an output stall has held the pipe; it stays high until the queue has
// popped an entry after that output stall ends.
module catmull_rom_segment_eval_unit #(
  parameter int unsigned CoordBits  = crs_pkg::CRS_COORD_BITS,
  parameter int unsigned FracBits   = crs_pkg::CRS_FRAC_BITS,
  parameter int unsigned QueueDepth = crs_pkg::CRS_QUEUE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [CoordBits-1:0] p0_x_i,
  input  logic signed [CoordBits-1:0] p0_y_i,
  input  logic signed [CoordBits-1:0] p1_x_i,
  input  logic signed [CoordBits-1:0] p1_y_i,
  input  logic signed [CoordBits-1:0] p2_x_i,
  input  logic signed [CoordBits-1:0] p2_y_i,
  input  logic signed [CoordBits-1:0] p3_x_i,
  input  logic signed [CoordBits-1:0] p3_y_i,
  input  logic        [FracBits:0]    frac_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [CoordBits+1:0] out_x_o,
  output logic signed [CoordBits+1:0] out_y_o
);

  localparam int unsigned PayBits = 2 * (4 * CoordBits + 9) + FracBits + 1;

  crs_pkg::q_stat_t   q_stat;
  logic               push;
  logic               pop;
  logic [PayBits-1:0] push_data;
  logic [PayBits-1:0] pop_data;

  crs_front #(
    .CoordBits (CoordBits),
    .FracBits  (FracBits),
    .PayBits   (PayBits)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .p0_x_i      (p0_x_i),
    .p0_y_i      (p0_y_i),
    .p1_x_i      (p1_x_i),
    .p1_y_i      (p1_y_i),
    .p2_x_i      (p2_x_i),
    .p2_y_i      (p2_y_i),
    .p3_x_i      (p3_x_i),
    .p3_y_i      (p3_y_i),
    .frac_i      (frac_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  crs_queue #(
    .Width (PayBits),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .q_stat_o    (q_stat)
  );

  crs_back #(
    .CoordBits (CoordBits),
    .FracBits  (FracBits),
    .PayBits   (PayBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o)
  );

endmodule

/* design/crs_front.sv */
`timescale 1ns / 1ps
module crs_front #(
  parameter int unsigned CoordBits = crs_pkg::CRS_COORD_BITS,
  parameter int unsigned FracBits  = crs_pkg::CRS_FRAC_BITS,
  parameter int unsigned PayBits   = 2 * (4 * CoordBits + 9) + FracBits + 1
) (
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [CoordBits-1:0] p0_x_i,
  input  logic signed [CoordBits-1:0] p0_y_i,
  input  logic signed [CoordBits-1:0] p1_x_i,
  input  logic signed [CoordBits-1:0] p1_y_i,
  input  logic signed [CoordBits-1:0] p2_x_i,
  input  logic signed [CoordBits-1:0] p2_y_i,
  input  logic signed [CoordBits-1:0] p3_x_i,
  input  logic signed [CoordBits-1:0] p3_y_i,
  input  logic        [FracBits:0]    frac_i,
  input  crs_pkg::q_stat_t            q_stat_i,
  output logic                        push_o,
  output logic        [PayBits-1:0]   push_data_o
);

  localparam int unsigned CW = CoordBits + 4;
  localparam int unsigned LaneBits = 4 * CoordBits + 9;
  localparam logic [FracBits:0] FracOne = {1'b1, {FracBits{1'b0}}};

  logic [FracBits:0]  frac_sat;
  logic [LaneBits-1:0] lane_x;
  logic [LaneBits-1:0] lane_y;

  // Build the start point and polynomial coefficients of one coordinate
  function automatic logic [LaneBits-1:0] lane_coeffs(
    input logic signed [CoordBits-1:0] a,
    input logic signed [CoordBits-1:0] b,
    input logic signed [CoordBits-1:0] c,
    input logic signed [CoordBits-1:0] d
  );
    logic signed [CW-1:0]      ax;
    logic signed [CW-1:0]      bx;
    logic signed [CW-1:0]      cx;
    logic signed [CW-1:0]      dx;
    logic signed [CoordBits:0] c1;
    logic signed [CW-1:0]      c2;
    logic signed [CW-1:0]      c3;
    ax = $signed({{4{a[CoordBits-1]}}, a});
    bx = $signed({{4{b[CoordBits-1]}}, b});
    cx = $signed({{4{c[CoordBits-1]}}, c});
    dx = $signed({{4{d[CoordBits-1]}}, d});
    c1 = $signed({c[CoordBits-1], c}) - $signed({a[CoordBits-1], a});
    c2 = (ax <<< 1) - ((bx <<< 2) + bx) + (cx <<< 2) - dx;
    c3 = ((bx <<< 1) + bx) - ((cx <<< 1) + cx) + dx - ax;
    return {b, c1, c2, c3};
  endfunction

  // Clamp the fraction at exactly one
  always_comb begin
    if (frac_i > FracOne) begin
      frac_sat = FracOne;
    end else begin
      frac_sat = frac_i;
    end
  end

  assign lane_x = lane_coeffs(p0_x_i, p1_x_i, p2_x_i, p3_x_i);
  assign lane_y = lane_coeffs(p0_y_i, p1_y_i, p2_y_i, p3_y_i);

  // Hand the item to the queue while it has room
  assign in_stall_o  = q_stat_i.full;
  assign push_o      = in_valid_i && !q_stat_i.full;
  assign push_data_o = {lane_y, lane_x, frac_sat};

endmodule

/* design/crs_queue.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module crs_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = crs_pkg::CRS_QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o,
  output crs_pkg::q_stat_t q_stat_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned NW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);
  localparam logic [NW-1:0] FullCnt = NW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]    count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign q_stat_o.full  = (count_q == FullCnt);
  assign q_stat_o.empty = (count_q == '0);
  assign do_push = push_i && !q_stat_o.full;
  assign do_pop  = pop_i && !q_stat_o.empty;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `CRS_ASSERT_NEVER(a_no_underflow, pop_i && q_stat_o.empty, "pop from empty queue")
  `CRS_ASSERT(a_count_bound, count_q <= FullCnt, "queue count beyond depth")

endmodule

/* design/crs_back.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module crs_back #(
  parameter int unsigned CoordBits = crs_pkg::CRS_COORD_BITS,
  parameter int unsigned FracBits  = crs_pkg::CRS_FRAC_BITS,
  parameter int unsigned PayBits   = 2 * (4 * CoordBits + 9) + FracBits + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  crs_pkg::q_stat_t              q_stat_i,
  input  logic        [PayBits-1:0]     pop_data_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [CoordBits+1:0]   out_x_o,
  output logic signed [CoordBits+1:0]   out_y_o
);

  localparam int unsigned C  = CoordBits;
  localparam int unsigned F  = FracBits;
  localparam int unsigned CW = C + 4;
  localparam int unsigned LaneBits = 4 * C + 9;
  localparam int unsigned W1 = C + F + 5;
  localparam int unsigned W2 = C + 2 * F + 6;
  localparam int unsigned WH = C + 2 * F + 7;
  localparam int unsigned WL = 2 * F + 1;
  localparam int unsigned W3 = C + 3 * F + 7;

  // Stage valids
  logic v1_q, v2_q, v3_q, vo_q;
  logic en;

  // Fraction carried down the pipe
  logic [F:0] f0;
  logic [F:0] f1_q, f2_q;

  // Per-coordinate stage registers
  logic signed [C-1:0]  b1_q  [2];
  logic signed [C-1:0]  b2_q  [2];
  logic signed [C-1:0]  b3_q  [2];
  logic signed [C:0]    c1_q  [2];
  logic signed [W1-1:0] acc1_q [2];
  logic signed [W2-1:0] acc2_q [2];
  logic signed [WH-1:0] hi_q  [2];
  logic        [WL-1:0] lo_q  [2];
  logic signed [C+1:0]  out_q [2];

  // Combinational stage results
  logic signed [W1-1:0] acc1_d [2];
  logic signed [W2-1:0] acc2_d [2];
  logic signed [WH-1:0] hi_d   [2];
  logic        [WL-1:0] lo_d   [2];
  logic signed [W3-1:0] acc3   [2];
  logic signed [F+1:0]  fs0, fs1, fs2;
  logic [LaneBits-1:0]  lane [2];

  // Advance the whole pipe unless a finished result is held
  assign en    = !(vo_q && out_stall_i);
  assign pop_o = en && !q_stat_i.empty;

  assign f0      = pop_data_i[F:0];
  assign lane[0] = pop_data_i[F+1 +: LaneBits];
  assign lane[1] = pop_data_i[F+1+LaneBits +: LaneBits];
  assign fs0 = $signed({1'b0, f0});
  assign fs1 = $signed({1'b0, f1_q});
  assign fs2 = $signed({1'b0, f2_q});

  for (genvar g = 0; g < 2; g++) begin : g_lane
    logic signed [CW-1:0] c2_in;
    logic signed [CW-1:0] c3_in;
    logic signed [W2-F-1:0] acc2_hi;

    assign c3_in = $signed(lane[g][CW-1:0]);
    assign c2_in = $signed(lane[g][CW +: CW]);

    // Horner step one: c3*u + c2
    assign acc1_d[g] = c3_in * fs0 + (W1'(c2_in) <<< F);

    // Horner step two: acc1*u + c1
    assign acc2_d[g] = acc1_q[g] * fs1 + (W2'(c1_q[g]) <<< (2 * F));

    // Horner step three, split into high and low partial products
    assign acc2_hi  = $signed(acc2_q[g][W2-1:F]);
    assign hi_d[g]  = acc2_hi * fs2;
    assign lo_d[g]  = acc2_q[g][F-1:0] * f2_q;

    // Recombine, add start point and rounding half
    assign acc3[g] = $signed({hi_q[g], {F{1'b0}}})
                   + $signed({1'b0, lo_q[g]})
                   + $signed({b3_q[g], 1'b1, {(3 * F){1'b0}}});

    always_ff @(posedge clk_i) begin
      if (en) begin
        b1_q[g]   <= $signed(lane[g][2*CW+C+1 +: C]);
        c1_q[g]   <= $signed(lane[g][2*CW +: C+1]);
        acc1_q[g] <= acc1_d[g];
        b2_q[g]   <= b1_q[g];
        acc2_q[g] <= acc2_d[g];
        b3_q[g]   <= b2_q[g];
        hi_q[g]   <= hi_d[g];
        lo_q[g]   <= lo_d[g];
        out_q[g]  <= acc3[g][3*F+1 +: C+2];
      end
    end
  end

  // Carry the fraction alongside
  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_q <= f0;
      f2_q <= f1_q;
    end
  end

  // Move stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= !q_stat_i.empty;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  assign out_valid_o = vo_q;
  assign out_x_o     = out_q[0];
  assign out_y_o     = out_q[1];

  `CRS_ASSERT(a_pop_when_moving, pop_o |-> en, "queue popped while pipe is held")
  `CRS_ASSERT(a_last_stage_lands, (v3_q && en) |=> vo_q, "item lost at output stage")
  `CRS_ASSERT(a_hold_when_stalled, !en |=> $stable(v1_q) && $stable(v3_q),
              "pipe moved while held")

endmodule
